>>> hdl/gbrce_pkg.sv
// shared constants, types and codes of the rgb gaussian blur block
package gbrce_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;

    localparam int DIM_W  = 11;                 // frame_width / frame_height fields
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RING_W = $clog2(RING_ROWS);
    localparam int ADDR_W = RING_W + COL_W;
    localparam int TAP_W  = 17;
    localparam int WGT_W  = 2 * TAP_W;
    localparam int ACC_W  = WGT_W + 8 + 6;      // 49 products of 8 x 34 bits
    localparam int IDX_W  = 3;
    localparam int RAD_W  = 2;
    localparam int OFS_W  = 4;                  // signed window offset

    // register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_RADIUS = 3'd2,
        REG_TAP0   = 3'd3,
        REG_TAP1   = 3'd4,
        REG_TAP2   = 3'd5,
        REG_TAP3   = 3'd6
    } reg_idx_t;

    // item kind on s_tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ADDR,
        ST_DATA,
        ST_ACC,
        ST_WRITE,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic addr;
        logic data;
        logic acc;
        logic write;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic win_ready;
        logic hit;
        logic last_elem;
        logic out_free;
    } dp_sts_t;

endpackage

>>> hdl/gbrce_ctrl.sv
// controller state machine: sequences accept, window walk, store write and emit
module gbrce_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  gbrce_pkg::dp_sts_t   sts,
    output gbrce_pkg::ctrl_cmd_t cmd
);

    gbrce_pkg::state_t state_reg;
    gbrce_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbrce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbrce_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = gbrce_pkg::ST_EVAL;
                end
            end
            gbrce_pkg::ST_EVAL:
            begin
                state_next = sts.win_ready ? gbrce_pkg::ST_ADDR : gbrce_pkg::ST_WRITE;
            end
            gbrce_pkg::ST_ADDR:  state_next = gbrce_pkg::ST_DATA;
            gbrce_pkg::ST_DATA:  state_next = gbrce_pkg::ST_ACC;
            gbrce_pkg::ST_ACC:
            begin
                state_next = sts.last_elem ? gbrce_pkg::ST_WRITE : gbrce_pkg::ST_ADDR;
            end
            gbrce_pkg::ST_WRITE:
            begin
                state_next = sts.hit ? gbrce_pkg::ST_EMIT : gbrce_pkg::ST_IDLE;
            end
            gbrce_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = gbrce_pkg::ST_IDLE;
                end
            end
            default: state_next = gbrce_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            gbrce_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            gbrce_pkg::ST_EVAL:  cmd.start = 1'b1;
            gbrce_pkg::ST_ADDR:  cmd.addr  = 1'b1;
            gbrce_pkg::ST_DATA:  cmd.data  = 1'b1;
            gbrce_pkg::ST_ACC:   cmd.acc   = 1'b1;
            gbrce_pkg::ST_WRITE: cmd.write = 1'b1;
            gbrce_pkg::ST_EMIT:  cmd.emit  = sts.out_free;
            default:             cmd       = '0;
        endcase
    end

endmodule

>>> hdl/gbrce_dp.sv
// datapath: config registers, counters, line store, window walk and accumulators
module gbrce_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [16:0]          cfg_data,
    input  logic                 s_tuser,
    input  logic [23:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tlast,
    input  gbrce_pkg::ctrl_cmd_t cmd,
    output gbrce_pkg::dp_sts_t   sts
);

    localparam int DW = gbrce_pkg::DIM_W;
    localparam int CW = gbrce_pkg::COL_W;
    localparam int RW = gbrce_pkg::RING_W;
    localparam int OW = gbrce_pkg::OFS_W;
    localparam int AW = gbrce_pkg::ACC_W;
    localparam int WW = gbrce_pkg::WGT_W;

    // configuration
    logic [DW-1:0]                  width_reg;
    logic [DW-1:0]                  height_reg;
    logic [gbrce_pkg::RAD_W-1:0]    radius_reg;
    logic [gbrce_pkg::TAP_W-1:0]    tap_reg [0:3];

    // frame counters
    logic [DW-1:0] recv_row_reg;
    logic [CW-1:0] recv_col_reg;
    logic [RW-1:0] recv_ring_reg;
    logic [DW-1:0] emit_row_reg;
    logic [CW-1:0] emit_col_reg;
    logic [RW-1:0] emit_ring_reg;

    // item held during processing
    logic          take_reg;
    logic [23:0]   pix_reg;
    logic [DW-1:0] pr_reg;
    logic [CW-1:0] pc_reg;
    logic [RW-1:0] pr_ring_reg;
    logic          hit_reg;

    // window walk
    logic signed [OW-1:0]     k_reg;
    logic signed [OW-1:0]     l_reg;
    logic [gbrce_pkg::ADDR_W-1:0] addr_reg;
    logic                     byp_reg;
    logic [WW-1:0]            wgt_reg;
    logic [23:0]              mem_q;
    logic [AW-1:0]            acc_r_reg;
    logic [AW-1:0]            acc_g_reg;
    logic [AW-1:0]            acc_b_reg;

    logic [23:0] mem [0:gbrce_pkg::RING_ROWS*gbrce_pkg::MAX_WIDTH-1];

    logic          out_valid_reg;
    logic [23:0]   out_data_reg;
    logic          out_last_reg;

    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [gbrce_pkg::RAD_W-1:0] r_eff;
    logic [DW:0]   nr;
    logic [DW:0]   nc;
    logic          ready_c;
    logic          geom_wr;
    logic          frame_end;
    logic signed [OW-1:0] r_s;
    logic signed [DW+1:0] y_s;
    logic signed [DW+1:0] x_s;
    logic [DW-1:0] y_row;
    logic [CW-1:0] x_col;
    logic signed [DW+1:0] dy_s;
    logic signed [RW+1:0] ring_s;
    logic [RW-1:0] ring;
    logic [1:0]    ak;
    logic [1:0]    al;
    logic [23:0]   src;
    logic [WW+7:0] prod_r;
    logic [WW+7:0] prod_g;
    logic [WW+7:0] prod_b;

    function automatic logic [7:0] sat8(input logic [AW-1:0] a);
        logic [AW-33:0] hi;
        hi = a[AW-1:32];
        sat8 = (hi > (AW-32)'(255)) ? 8'hff : hi[7:0];
    endfunction

    // effective geometry
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DW'(1);
        else if (width_reg > DW'(gbrce_pkg::MAX_WIDTH))
            w_eff = DW'(gbrce_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DW'(1);
        else if (height_reg > DW'(gbrce_pkg::MAX_HEIGHT))
            h_eff = DW'(gbrce_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
        r_eff = (32'(radius_reg) > gbrce_pkg::MAX_RADIUS)
              ? gbrce_pkg::RAD_W'(gbrce_pkg::MAX_RADIUS) : radius_reg;
        r_s   = $signed({{(OW-gbrce_pkg::RAD_W){1'b0}}, r_eff});
    end

    // window completeness of the next output pixel
    always_comb
    begin
        nr = {1'b0, emit_row_reg} + (DW+1)'(r_eff);
        if (nr > {1'b0, h_eff} - 1'b1)
            nr = {1'b0, h_eff} - 1'b1;
        nc = (DW+1)'(emit_col_reg) + (DW+1)'(r_eff);
        if (nc > {1'b0, w_eff} - 1'b1)
            nc = {1'b0, w_eff} - 1'b1;
        ready_c = (emit_row_reg < h_eff)
               && (({1'b0, recv_row_reg} > nr)
                   || (({1'b0, recv_row_reg} == nr) && ((DW+1)'(recv_col_reg) > nc)));
    end

    // window position of the current element
    always_comb
    begin
        y_s = $signed({2'b00, emit_row_reg}) + $signed({{(DW+2-OW){k_reg[OW-1]}}, k_reg});
        x_s = $signed({3'b000, emit_col_reg}) + $signed({{(DW+2-OW){l_reg[OW-1]}}, l_reg});
        if (y_s < 0)
            y_row = '0;
        else if (y_s > $signed({2'b00, h_eff}) - 1)
            y_row = h_eff - 1'b1;
        else
            y_row = y_s[DW-1:0];
        if (x_s < 0)
            x_col = '0;
        else if (x_s > $signed({2'b00, w_eff}) - 1)
            x_col = CW'(w_eff - 1'b1);
        else
            x_col = x_s[CW-1:0];
        dy_s   = $signed({2'b00, y_row}) - $signed({2'b00, emit_row_reg});
        ring_s = $signed({2'b00, emit_ring_reg}) + $signed(dy_s[RW+1:0]);
        if (ring_s < 0)
            ring_s = ring_s + (RW+2)'(gbrce_pkg::RING_ROWS);
        else if (ring_s >= $signed((RW+2)'(gbrce_pkg::RING_ROWS)))
            ring_s = ring_s - (RW+2)'(gbrce_pkg::RING_ROWS);
        ring = ring_s[RW-1:0];
        ak   = k_reg[OW-1] ? 2'(-k_reg) : k_reg[1:0];
        al   = l_reg[OW-1] ? 2'(-l_reg) : l_reg[1:0];
    end

    assign geom_wr = cfg_valid && ((cfg_index == gbrce_pkg::REG_WIDTH)
                                || (cfg_index == gbrce_pkg::REG_HEIGHT)
                                || (cfg_index == gbrce_pkg::REG_RADIUS));
    assign frame_end = (emit_row_reg == h_eff - 1'b1) && ((DW)'(emit_col_reg) == w_eff - 1'b1);
    assign src = byp_reg ? pix_reg : mem_q;

    // full-width products of one window element
    assign prod_r = src[23:16] * wgt_reg;
    assign prod_g = src[15:8] * wgt_reg;
    assign prod_b = src[7:0] * wgt_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(1024);
            height_reg <= DW'(1024);
            radius_reg <= 2'd1;
            tap_reg[0] <= 17'd65536;
            tap_reg[1] <= '0;
            tap_reg[2] <= '0;
            tap_reg[3] <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gbrce_pkg::REG_WIDTH:  width_reg  <= cfg_data[DW-1:0];
                gbrce_pkg::REG_HEIGHT: height_reg <= cfg_data[DW-1:0];
                gbrce_pkg::REG_RADIUS: radius_reg <= cfg_data[1:0];
                gbrce_pkg::REG_TAP0:   tap_reg[0] <= cfg_data;
                gbrce_pkg::REG_TAP1:   tap_reg[1] <= cfg_data;
                gbrce_pkg::REG_TAP2:   tap_reg[2] <= cfg_data;
                gbrce_pkg::REG_TAP3:   tap_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // receive and emit counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_row_reg  <= '0;
            recv_col_reg  <= '0;
            recv_ring_reg <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_ring_reg <= '0;
            take_reg      <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else if (geom_wr || (cmd.emit && frame_end))
        begin
            recv_row_reg  <= '0;
            recv_col_reg  <= '0;
            recv_ring_reg <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_ring_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                take_reg <= (s_tuser == gbrce_pkg::CMD_PIXEL) && (recv_row_reg < h_eff);
                if ((s_tuser == gbrce_pkg::CMD_PIXEL) && (recv_row_reg < h_eff))
                begin
                    if ((DW)'(recv_col_reg) + 1'b1 >= w_eff)
                    begin
                        recv_col_reg <= '0;
                        recv_row_reg <= recv_row_reg + 1'b1;
                        recv_ring_reg <= (recv_ring_reg == RW'(gbrce_pkg::RING_ROWS - 1))
                                       ? '0 : recv_ring_reg + 1'b1;
                    end
                    else
                    begin
                        recv_col_reg <= recv_col_reg + 1'b1;
                    end
                end
            end
            if (cmd.start)
            begin
                hit_reg <= ready_c;
            end
            if (cmd.emit)
            begin
                if ((DW)'(emit_col_reg) + 1'b1 >= w_eff)
                begin
                    emit_col_reg  <= '0;
                    emit_row_reg  <= emit_row_reg + 1'b1;
                    emit_ring_reg <= (emit_ring_reg == RW'(gbrce_pkg::RING_ROWS - 1))
                                   ? '0 : emit_ring_reg + 1'b1;
                end
                else
                begin
                    emit_col_reg <= emit_col_reg + 1'b1;
                end
            end
        end
    end

    // item payload and window walk
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg     <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
            pr_reg      <= recv_row_reg;
            pc_reg      <= recv_col_reg;
            pr_ring_reg <= recv_ring_reg;
        end
        if (cmd.start)
        begin
            k_reg     <= -r_s;
            l_reg     <= -r_s;
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
        end
        if (cmd.addr)
        begin
            addr_reg <= {ring, x_col};
            byp_reg  <= take_reg && (y_row == pr_reg) && (x_col == pc_reg);
            wgt_reg  <= tap_reg[ak] * tap_reg[al];
        end
        if (cmd.acc)
        begin
            acc_r_reg <= acc_r_reg + AW'(prod_r);
            acc_g_reg <= acc_g_reg + AW'(prod_g);
            acc_b_reg <= acc_b_reg + AW'(prod_b);
            if (l_reg == r_s)
            begin
                l_reg <= -r_s;
                k_reg <= k_reg + 1'b1;
            end
            else
            begin
                l_reg <= l_reg + 1'b1;
            end
        end
    end

    // line store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write && take_reg)
        begin
            mem[{pr_ring_reg, pc_reg}] <= pix_reg;
        end
        if (cmd.data)
        begin
            mem_q <= mem[addr_reg];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {sat8(acc_b_reg), sat8(acc_g_reg), sat8(acc_r_reg)};
            out_last_reg <= frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign sts.win_ready = ready_c;
    assign sts.hit       = hit_reg;
    assign sts.last_elem = (k_reg == r_s) && (l_reg == r_s);
    assign sts.out_free  = !out_valid_reg || m_tready;

endmodule

>>> hdl/gaussian_blur_rgb_clamp_edge.sv
// top level of the rgb gaussian blur with clamp-to-edge borders
//
//  channel | signals                           | carries
//  --------+-----------------------------------+--------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser | pixel or drain request
//  out     | m_tvalid m_tready m_tdata m_tlast | blurred pixel, tlast on frame end
//  config  | cfg_valid cfg_ready cfg_index/data| register write request
//
// an item that leaves no output pixel due passes only through the eval and write states;
// when one is due, the window is walked one element at a time through the single
// read port of the line store, one multiply-accumulate per color per element.
// reset clears control state, sets the default config; the line store is not cleared.
// a finished pixel waits in the output register; the next request is taken meanwhile,
// and the block stalls only when a new pixel is due while the last is still untaken.
module gaussian_blur_rgb_clamp_edge (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_blue, in_green, in_red
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_blue, out_green, out_red
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    gbrce_pkg::ctrl_cmd_t cmd;
    gbrce_pkg::dp_sts_t   sts;

    assign cfg_ready = 1'b1;

    gbrce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbrce_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // a request is processed before the next one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one in progress");

    // a pixel is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // a loaded pixel shows up as valid next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("emitted pixel not presented");

endmodule
